/* rtl/core/ibca_pkg.sv */
// Shared types and constants for the interval bin count accumulator.
// This package has no dependencies. Every module in rtl/core imports it.
package ibca_pkg;

  // Storage sizes.
  localparam int MAX_BINS    = 1024;
  localparam int MAX_SAMPLES = 64;
  localparam int QUEUE_DEPTH = 2;

  // Field and register widths.
  localparam int SLOT_W     = 10;
  localparam int SAMPLE_W   = 6;
  localparam int BIN_CNT_W  = 11;
  localparam int SAMP_CNT_W = 7;
  localparam int DATA_W     = 32;
  localparam int MAT_AW     = SLOT_W + SAMPLE_W;
  localparam int CFG_DATA_W = 11;
  localparam int FILL_W     = 2;

  // Limits in register width.
  localparam logic [BIN_CNT_W-1:0]  BINS_LIMIT    = 11'd1024;
  localparam logic [SAMP_CNT_W-1:0] SAMPLES_LIMIT = 7'd64;
  localparam logic [FILL_W-1:0]     FILL_LIMIT    = 2'd2;

  // Request modes.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ACC  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BIN_COUNT    = 1'b0;
  localparam logic CFG_SAMPLE_COUNT = 1'b1;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic [1:0]          mode;
    logic [SLOT_W-1:0]   bin;
    logic                miss;
    logic [SAMPLE_W-1:0] sample_id;
    logic [DATA_W-1:0]   copies;
  } op_t;

  // One result as it waits for the consumer.
  typedef struct packed {
    logic [SLOT_W-1:0] bin_index;
    logic              miss;
    logic [DATA_W-1:0] cell_value;
    logic              saturated;
  } result_t;

endpackage

/* rtl/core/ibca_queue.sv */
// Two-entry request queue between the search front and the count back.
// Depends on ibca_pkg for op_t and the queue depth.
module ibca_queue import ibca_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  pop_op,
  output logic empty
);

  op_t               entries [QUEUE_DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == FILL_LIMIT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // The fill level never passes the depth.
  assert property (@(posedge clk) disable iff (rst) fill <= FILL_LIMIT)
    else $error("request queue overfilled");

endmodule

/* rtl/core/ibca_front.sv */
// Front end: takes requests, writes bin starts and runs the floor search.
// Depends on ibca_pkg. Feeds classified requests into ibca_queue.
module ibca_front import ibca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hold,
  input  logic [BIN_CNT_W-1:0] eff_bins,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           mode,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [DATA_W-1:0]    position,
  input  logic [SAMPLE_W-1:0]  sample_id,
  input  logic [DATA_W-1:0]    copies,
  output logic                 q_push,
  output op_t                  q_op,
  input  logic                 q_full
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [BIN_CNT_W-1:0] lo;
  logic [BIN_CNT_W-1:0] hi;
  logic [BIN_CNT_W-1:0] lo_next;
  logic [BIN_CNT_W-1:0] hi_next;
  logic [BIN_CNT_W-1:0] mid;
  logic [BIN_CNT_W-1:0] mid_next;
  logic [DATA_W-1:0]    pos_q;
  logic [SAMPLE_W-1:0]  samp_q;
  logic [DATA_W-1:0]    copies_q;
  logic [DATA_W-1:0]    bin_starts [MAX_BINS];
  logic [DATA_W-1:0]    rd_data;
  logic                 accept;
  logic                 done;

  assign full   = (state != ST_IDLE) || q_full || hold;
  assign accept = push && !full;
  assign done   = (state == ST_SEARCH) && !(lo < hi);

  // Search bounds. The table entry read last cycle sits at the current midpoint.
  always_comb begin
    mid     = lo + ((hi - lo) >> 1);
    lo_next = lo;
    hi_next = hi;
    if (state == ST_IDLE) begin
      lo_next = '0;
      hi_next = eff_bins;
    end else if (lo < hi) begin
      if (rd_data <= pos_q) begin
        lo_next = mid + 1'b1;
      end else begin
        hi_next = mid;
      end
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_ACC)) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (done && !q_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search registers and the captured request.
  always_ff @(posedge clk) begin
    if (accept || (state == ST_SEARCH)) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (accept) begin
      pos_q    <= position;
      samp_q   <= sample_id;
      copies_q <= copies;
    end
  end

  // Bin start table: one write port for loads, one registered read for probes.
  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_LOAD)) begin
      bin_starts[slot] <= position;
    end
    rd_data <= bin_starts[mid_next[SLOT_W-1:0]];
  end

  // Requests other than accumulate pass straight on; accumulate waits for the search.
  always_comb begin
    q_push       = 1'b0;
    q_op.mode      = mode;
    q_op.bin       = slot;
    q_op.miss      = 1'b0;
    q_op.sample_id = sample_id;
    q_op.copies    = copies;
    if (state == ST_SEARCH) begin
      q_push         = done && !q_full;
      q_op.mode      = MODE_ACC;
      q_op.miss      = (lo == '0);
      q_op.bin       = (lo == '0) ? '0 : SLOT_W'(lo - 1'b1);
      q_op.sample_id = samp_q;
      q_op.copies    = copies_q;
    end else begin
      q_push = accept && (mode != MODE_ACC);
    end
  end

  // The search window never inverts.
  assert property (@(posedge clk) disable iff (rst) (state == ST_SEARCH) |-> (lo <= hi))
    else $error("search bounds crossed");

  // A search hands on its request only once the window has closed.
  assert property (@(posedge clk) disable iff (rst)
    (q_push && (state == ST_SEARCH)) |-> (lo == hi))
    else $error("search request issued before the search finished");

endmodule

/* rtl/core/ibca_back.sv */
// Back end: clears and updates the count matrix and buffers the results.
// Depends on ibca_pkg. Takes requests from ibca_queue.
module ibca_back import ibca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SAMP_CNT_W-1:0] eff_samples,
  input  logic                  q_empty,
  input  op_t                   q_op,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [MAT_AW-1:0] clear_addr;
  op_t               op_q;
  logic              samp_ok_q;
  logic              samp_ok;

  logic [DATA_W-1:0] count_matrix [MAX_BINS*MAX_SAMPLES];
  logic [DATA_W-1:0] mat_rdata;
  logic              mat_we;
  logic [MAT_AW-1:0] mat_waddr;
  logic [DATA_W-1:0] mat_wdata;

  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] new_val;
  logic              acc_hit;
  result_t           res_new;
  logic              res_push;

  result_t           res_buf [QUEUE_DEPTH];
  logic              out_wr;
  logic              out_rd;
  logic [FILL_W-1:0] out_fill;
  logic              res_pop;

  assign clearing = (state == ST_CLEAR);
  assign samp_ok  = ({1'b0, q_op.sample_id} < eff_samples);
  assign q_pop    = (state == ST_IDLE) && !q_empty && (out_fill < FILL_LIMIT);
  assign res_push = (state == ST_EXEC);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Captured request.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_q      <= q_op;
      samp_ok_q <= samp_ok;
    end
  end

  // Saturating add on the cell read back.
  always_comb begin
    sum     = {1'b0, mat_rdata} + {1'b0, op_q.copies};
    new_val = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
    acc_hit = (op_q.mode == MODE_ACC) && !op_q.miss && samp_ok_q;
  end

  // Matrix write: zero sweep after reset, then accumulate updates.
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = {op_q.bin, op_q.sample_id};
    mat_wdata = new_val;
    if (state == ST_CLEAR) begin
      mat_we    = 1'b1;
      mat_waddr = clear_addr;
      mat_wdata = '0;
    end else if ((state == ST_EXEC) && acc_hit) begin
      mat_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      count_matrix[mat_waddr] <= mat_wdata;
    end
    mat_rdata <= count_matrix[{q_op.bin, q_op.sample_id}];
  end

  // Result fields.
  always_comb begin
    res_new.bin_index  = op_q.bin;
    res_new.miss       = op_q.miss;
    res_new.cell_value = '0;
    res_new.saturated  = 1'b0;
    if (acc_hit) begin
      res_new.cell_value = new_val;
      res_new.saturated  = sum[DATA_W];
    end else if ((op_q.mode == MODE_READ) && samp_ok_q) begin
      res_new.cell_value = mat_rdata;
    end
  end

  // Result buffer toward the consumer.
  assign empty   = (out_fill == '0);
  assign res_pop = pop && !empty;
  assign result  = res_buf[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr   <= 1'b0;
      out_rd   <= 1'b0;
      out_fill <= '0;
    end else begin
      if (res_push) begin
        out_wr <= out_wr + 1'b1;
      end
      if (res_pop) begin
        out_rd <= out_rd + 1'b1;
      end
      case ({res_push, res_pop})
        2'b10:   out_fill <= out_fill + 1'b1;
        2'b01:   out_fill <= out_fill - 1'b1;
        default: out_fill <= out_fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_buf[out_wr] <= res_new;
    end
  end

  // Every result follows a request taken from the queue in the previous cycle.
  assert property (@(posedge clk) disable iff (rst) res_push |-> $past(q_pop))
    else $error("result produced without a request");

  // A result is never pushed into a full buffer.
  assert property (@(posedge clk) disable iff (rst) res_push |-> (out_fill < FILL_LIMIT))
    else $error("result buffer overflow");

endmodule

/* rtl/core/interval_bin_count_accumulator_unit.sv */
// Top level of the interval bin count accumulator: configuration registers,
// search front, request queue and count back. Depends on ibca_pkg and rtl/core modules.
//
// After reset the block sweeps the 65536-cell count matrix to zero, one cell per
// cycle, and holds full high during the sweep; configuration writes are taken
// throughout. Afterwards a load, read or unused-mode request passes through the
// queue, the back's capture register and the result buffer before its result is
// on the result ports. An accumulate request makes up to ceil(log2(bin_count + 1))
// probes of the bin start table, so eleven for 1024 bins, then is handed to the
// queue, and the back does the matrix read-modify-write.
// The front takes the next request once its search has handed off, while the
// back is still updating the matrix and results wait in a two-entry buffer.
module interval_bin_count_accumulator_unit import ibca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            mode,
  input  logic [SLOT_W-1:0]     slot,
  input  logic [DATA_W-1:0]     position,
  input  logic [SAMPLE_W-1:0]   sample_id,
  input  logic [DATA_W-1:0]     copies,
  output logic                  empty,
  input  logic                  pop,
  output logic [SLOT_W-1:0]     bin_index,
  output logic                  miss,
  output logic [DATA_W-1:0]     cell_value,
  output logic                  saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BIN_CNT_W-1:0]  bin_count;
  logic [SAMP_CNT_W-1:0] sample_count;
  logic [BIN_CNT_W-1:0]  eff_bins;
  logic [SAMP_CNT_W-1:0] eff_samples;
  logic                  clearing;
  logic                  fq_push;
  op_t                   fq_op;
  logic                  fq_full;
  logic                  bq_pop;
  op_t                   bq_op;
  logic                  bq_empty;
  result_t               result;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count    <= BIN_CNT_W'(1);
      sample_count <= SAMP_CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIN_COUNT:    bin_count    <= cfg_data[BIN_CNT_W-1:0];
        CFG_SAMPLE_COUNT: sample_count <= cfg_data[SAMP_CNT_W-1:0];
        default:          bin_count    <= bin_count;
      endcase
    end
  end

  // Clamp the registers to the storage limits.
  assign eff_bins    = (bin_count > BINS_LIMIT) ? BINS_LIMIT : bin_count;
  assign eff_samples = (sample_count > SAMPLES_LIMIT) ? SAMPLES_LIMIT : sample_count;

  ibca_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .eff_bins  (eff_bins),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .slot      (slot),
    .position  (position),
    .sample_id (sample_id),
    .copies    (copies),
    .q_push    (fq_push),
    .q_op      (fq_op),
    .q_full    (fq_full)
  );

  ibca_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .push_op (fq_op),
    .full    (fq_full),
    .pop     (bq_pop),
    .pop_op  (bq_op),
    .empty   (bq_empty)
  );

  ibca_back u_back (
    .clk         (clk),
    .rst         (rst),
    .eff_samples (eff_samples),
    .q_empty     (bq_empty),
    .q_op        (bq_op),
    .q_pop       (bq_pop),
    .clearing    (clearing),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  // Result fields.
  assign bin_index  = result.bin_index;
  assign miss       = result.miss;
  assign cell_value = result.cell_value;
  assign saturated  = result.saturated;

endmodule

/* test/tb_interval_bin_count_accumulator_unit.sv */
// Self-checking testbench for the interval bin count accumulator unit.
// It predicts every result from its own copy of the bin start table and count matrix.
// Depends on ibca_pkg and the RTL under rtl/core.
module tb_interval_bin_count_accumulator_unit;
  import ibca_pkg::*;

  // The mode code that the block leaves unused.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic [1:0]            mode;
  logic [SLOT_W-1:0]     slot;
  logic [DATA_W-1:0]     position;
  logic [SAMPLE_W-1:0]   sample_id;
  logic [DATA_W-1:0]     copies;
  logic                  empty;
  logic                  pop;
  logic [SLOT_W-1:0]     bin_index;
  logic                  miss;
  logic [DATA_W-1:0]     cell_value;
  logic                  saturated;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted state: bin starts, count matrix and both registers.
  bit [DATA_W-1:0]       start_table [MAX_BINS];
  bit [DATA_W-1:0]       count_cells [MAX_BINS*MAX_SAMPLES];
  logic [BIN_CNT_W-1:0]  bin_count_reg = 11'd1;
  logic [SAMP_CNT_W-1:0] sample_count_reg = 7'd1;

  result_t     pending_tallies [$];
  int unsigned mismatch_count = 0;
  int unsigned rx_hold_cycles = 0;
  bit          steady_flow = 1'b0;

  interval_bin_count_accumulator_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned active_bins();
    return (bin_count_reg > MAX_BINS) ? MAX_BINS : bin_count_reg;
  endfunction

  function automatic int unsigned active_samples();
    return (sample_count_reg > MAX_SAMPLES) ? MAX_SAMPLES : sample_count_reg;
  endfunction

  // Works out the result of one request and applies it to the predicted state.
  function automatic result_t tally_request(input logic [1:0] m, input logic [SLOT_W-1:0] sl,
                                            input logic [DATA_W-1:0] pos,
                                            input logic [SAMPLE_W-1:0] sid,
                                            input logic [DATA_W-1:0] cp);
    result_t          r;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    logic [DATA_W:0]  sum;
    r = '0;
    r.bin_index = sl;
    case (m)
      MODE_LOAD: begin
        start_table[sl] = pos;
      end
      MODE_ACC: begin
        // Upper-bound search; the floor bin sits just below the bound.
        lo = 0;
        hi = active_bins();
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (start_table[mid] <= pos) lo = mid + 1;
          else hi = mid;
        end
        if (lo == 0) begin
          r.bin_index = '0;
          r.miss = 1'b1;
        end else begin
          r.bin_index = SLOT_W'(lo - 1);
          if (sid < active_samples()) begin
            sum = {1'b0, count_cells[{r.bin_index, sid}]} + {1'b0, cp};
            if (sum[DATA_W]) begin
              sum = {1'b0, {DATA_W{1'b1}}};
              r.saturated = 1'b1;
            end
            count_cells[{r.bin_index, sid}] = sum[DATA_W-1:0];
            r.cell_value = sum[DATA_W-1:0];
          end
        end
      end
      MODE_READ: begin
        if (sid < active_samples()) r.cell_value = count_cells[{sl, sid}];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    mismatch_count++;
    $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endtask

  // Offers one request until the block takes it, then maybe pauses.
  task automatic issue_request(input logic [1:0] m, input logic [SLOT_W-1:0] sl,
                               input logic [DATA_W-1:0] pos, input logic [SAMPLE_W-1:0] sid,
                               input logic [DATA_W-1:0] cp);
    int unsigned gap;
    push <= 1'b1;
    mode <= m;
    slot <= sl;
    position <= pos;
    sample_id <= sid;
    copies <= cp;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_tallies.push_back(tally_request(m, sl, pos, sid, cp));
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering, waits for every outstanding result, then lets the back settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BIN_COUNT) bin_count_reg = val;
    else sample_count_reg = val[SAMP_CNT_W-1:0];
    @(posedge clk);
  endtask

  // Bin choice that often lands on a few hot bins so cells build up.
  function automatic logic [SLOT_W-1:0] pick_bin(input int unsigned n);
    if (n == 0) return SLOT_W'($urandom_range(0, MAX_BINS - 1));
    if ($urandom_range(0, 1) == 0) return SLOT_W'($urandom_range(0, (n < 16 ? n : 16) - 1));
    return SLOT_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0)
      return SAMPLE_W'($urandom_range(0, MAX_SAMPLES - 1));
    if ($urandom_range(0, 1) == 0) return SAMPLE_W'($urandom_range(0, (n < 4 ? n : 4) - 1));
    return SAMPLE_W'($urandom_range(0, n - 1));
  endfunction

  // Field extremes, misses, saturation, every mode and the out-of-range cases.
  task automatic test_corner_cases();
    write_register(CFG_SAMPLE_COUNT, 11'd64);
    write_register(CFG_BIN_COUNT, 11'd4);
    issue_request(MODE_READ, 10'd1023, 32'd0, 6'd63, 32'd0);
    issue_request(MODE_READ, 10'd0, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF);
    issue_request(MODE_LOAD, 10'd0, 32'd100, 6'd0, 32'd0);
    issue_request(MODE_LOAD, 10'd1, 32'd200, 6'd0, 32'd0);
    issue_request(MODE_LOAD, 10'd2, 32'd300, 6'd0, 32'd0);
    issue_request(MODE_LOAD, 10'd3, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    issue_request(MODE_LOAD, 10'd1023, 32'd0, 6'd0, 32'd0);
    // Positions below the first start miss.
    issue_request(MODE_ACC, 10'd0, 32'd0, 6'd0, 32'd7);
    issue_request(MODE_ACC, 10'd0, 32'd99, 6'd0, 32'd7);
    issue_request(MODE_ACC, 10'd0, 32'd100, 6'd0, 32'd5);
    issue_request(MODE_ACC, 10'd0, 32'd299, 6'd63, 32'd0);
    issue_request(MODE_ACC, 10'd0, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    // The second add to a full cell clips.
    issue_request(MODE_ACC, 10'd1023, 32'hFFFF_FFFF, 6'd63, 32'd1);
    issue_request(MODE_ACC, 10'd0, 32'hFFFF_FFFE, 6'd63, 32'hFFFF_FFFF);
    issue_request(MODE_READ, 10'd3, 32'd0, 6'd63, 32'd0);
    issue_request(MODE_SPARE, 10'd1023, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    // A sample column beyond the configured count touches nothing.
    wait_idle();
    write_register(CFG_SAMPLE_COUNT, 11'd1);
    issue_request(MODE_ACC, 10'd0, 32'd150, 6'd1, 32'd9);
    issue_request(MODE_READ, 10'd0, 32'd0, 6'd1, 32'd0);
    issue_request(MODE_READ, 10'd0, 32'd0, 6'd0, 32'd0);
    // With no bins every accumulate misses.
    wait_idle();
    write_register(CFG_BIN_COUNT, 11'd0);
    issue_request(MODE_ACC, 10'd0, 32'hFFFF_FFFF, 6'd0, 32'd3);
    // No sample columns at all, and a search over an unsorted table.
    wait_idle();
    write_register(CFG_SAMPLE_COUNT, 11'd0);
    write_register(CFG_BIN_COUNT, 11'd4);
    issue_request(MODE_READ, 10'd0, 32'd0, 6'd0, 32'd0);
    issue_request(MODE_LOAD, 10'd2, 32'd50, 6'd0, 32'd0);
    issue_request(MODE_ACC, 10'd0, 32'd250, 6'd0, 32'd1);
    wait_idle();
  endtask

  // Loads the whole table with ascending starts spread over the position range.
  task automatic test_table_fill();
    logic [DATA_W-1:0] next_start;
    next_start = $urandom_range(1, 1000);
    for (int i = 0; i < MAX_BINS; i++) begin
      issue_request(MODE_LOAD, SLOT_W'(i), next_start, SAMPLE_W'($urandom_range(0, 63)),
                    $urandom);
      next_start += $urandom_range(1, 4_000_000);
    end
    wait_idle();
  endtask

  // The result side holds off while requests keep coming, so the block backs up.
  task automatic test_full_stall();
    write_register(CFG_BIN_COUNT, 11'd1024);
    write_register(CFG_SAMPLE_COUNT, 11'd64);
    rx_hold_cycles = 400;
    steady_flow = 1'b1;
    for (int i = 0; i < 20; i++)
      issue_request(MODE_ACC, '0, start_table[$urandom_range(0, MAX_BINS - 1)],
                    SAMPLE_W'($urandom_range(0, 3)), $urandom_range(0, 1000));
    steady_flow = 1'b0;
    wait_idle();
  endtask

  // Random traffic under several register settings, extremes among them.
  task automatic test_random_traffic();
    int unsigned          n_bins;
    int unsigned          n_samp;
    int unsigned          pick;
    int unsigned          k;
    logic [1:0]           m;
    logic [SLOT_W-1:0]    sl;
    logic [DATA_W-1:0]    pos;
    logic [DATA_W-1:0]    cp;
    logic [SAMPLE_W-1:0]  sid;
    logic [BIN_CNT_W-1:0] bins_setting;
    logic [CFG_DATA_W-1:0] samples_setting;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin bins_setting = BINS_LIMIT; samples_setting = SAMPLES_LIMIT; end
        1: begin bins_setting = '1; samples_setting = 11'd127; end
        2: begin bins_setting = 11'd1; samples_setting = 11'd1; end
        3: begin bins_setting = 11'd0; samples_setting = 11'd64; end
        4: begin
          bins_setting = BIN_CNT_W'($urandom_range(2, 1023));
          samples_setting = CFG_DATA_W'($urandom_range(2, 63));
        end
        default: begin bins_setting = 11'd513; samples_setting = 11'd33; end
      endcase
      wait_idle();
      write_register(CFG_BIN_COUNT, bins_setting);
      write_register(CFG_SAMPLE_COUNT, samples_setting);
      n_bins = active_bins();
      n_samp = active_samples();
      for (int i = 0; i < 160; i++) begin
        // Each setting opens with a stretch of back-to-back traffic.
        steady_flow = (i < 50);
        sl = pick_bin(n_bins);
        sid = pick_sample(n_samp);
        pick = $urandom_range(0, 99);
        if (pick < 60) cp = $urandom_range(0, 1000);
        else if (pick < 80) cp = $urandom;
        else cp = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // Mostly rewrite the same start so the table stays sorted.
          m = MODE_LOAD;
          pos = ($urandom_range(0, 4) == 0) ? $urandom : start_table[sl];
        end else if (pick < 70) begin
          m = MODE_ACC;
          k = 32'(pick_bin(n_bins));
          case ($urandom_range(0, 3))
            0: pos = start_table[k];
            1: pos = start_table[k] + $urandom_range(0, 5000);
            2: pos = start_table[k] - 1;
            default: pos = $urandom;
          endcase
        end else if (pick < 96) begin
          m = MODE_READ;
          pos = $urandom;
        end else begin
          m = MODE_SPARE;
          pos = $urandom;
        end
        issue_request(m, sl, pos, sid, cp);
      end
      steady_flow = 1'b0;
    end
  endtask

  // Result side: checks each accepted result against the oldest prediction.
  initial begin : result_side
    int unsigned stall;
    result_t     want;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_tallies.size() == 0) begin
          report_mismatch("result with no request waiting", '0, cell_value);
        end else begin
          want = pending_tallies.pop_front();
          if (bin_index !== want.bin_index)
            report_mismatch("bin_index", DATA_W'(want.bin_index), DATA_W'(bin_index));
          if (miss !== want.miss)
            report_mismatch("miss", DATA_W'(want.miss), DATA_W'(miss));
          if (cell_value !== want.cell_value)
            report_mismatch("cell_value", want.cell_value, cell_value);
          if (saturated !== want.saturated)
            report_mismatch("saturated", DATA_W'(want.saturated), DATA_W'(saturated));
        end
        stall = pick_gap();
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Main sequence.
  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    mode <= MODE_LOAD;
    slot <= '0;
    position <= '0;
    sample_id <= '0;
    copies <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BIN_COUNT;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_table_fill();
    test_full_stall();
    test_random_traffic();
    wait_idle();
    repeat (24) @(posedge clk);
    if (mismatch_count == 0 && pending_tallies.size() == 0) begin
      $display("interval_bin_count_accumulator_unit test passed");
    end else begin
      $display("interval_bin_count_accumulator_unit test failed");
    end
    $finish;
  end

  // Covers the matrix clear after reset and the slowest legal traffic many times over.
  initial begin
    #5_000_000;
    $display("interval_bin_count_accumulator_unit test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ibca_pkg.sv
rtl/core/ibca_queue.sv
rtl/core/ibca_front.sv
rtl/core/ibca_back.sv
rtl/core/interval_bin_count_accumulator_unit.sv
test/tb_interval_bin_count_accumulator_unit.sv
